>>> hdl/tasv_pkg.sv
// ----------------------------------------------------------------------------
// tasv_pkg
// Shared types, constants and character helpers for the archive validator.
// ----------------------------------------------------------------------------
package tasv_pkg;

    localparam int TABLE_DEPTH_DEF   = 1024;
    localparam int VERSION_MAX_DEF   = 32;
    localparam int NAME_MAX_DEF      = 255;
    localparam int MARKER_LENGTH     = 14;
    localparam int COUNT_DIGITS      = 7;
    localparam int SIZE_DIGITS       = 10;

    localparam logic [16:0] COUNT_CAP = 17'd65536;
    localparam logic [28:0] SIZE_CAP  = 29'h1000_0000;

    // configuration register indexes
    localparam logic CFG_MAX_COUNT = 1'b0;
    localparam logic CFG_MAX_BYTES = 1'b1;

    // error codes
    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_VERSION   = 4'd1;
    localparam logic [3:0] ERR_COUNT     = 4'd2;
    localparam logic [3:0] ERR_NAME      = 4'd3;
    localparam logic [3:0] ERR_SIZE      = 4'd4;
    localparam logic [3:0] ERR_MARKER    = 4'd5;
    localparam logic [3:0] ERR_TRUNCATED = 4'd6;
    localparam logic [3:0] ERR_TRAILING  = 4'd7;
    localparam logic [3:0] ERR_TABLE     = 4'd8;

    // parse flag bit positions
    localparam int FL_DOT       = 0;
    localparam int FL_PREVDOT   = 1;
    localparam int FL_ALLDOTS   = 2;
    localparam int FL_NAMEDONE  = 3;
    localparam int FL_SIZEBAD   = 4;
    localparam int FL_FIRSTZERO = 5;

    typedef enum logic [5:0] {
        PH_VERSION = 6'b000001,
        PH_COUNT   = 6'b000010,
        PH_DIR     = 6'b000100,
        PH_MARKER  = 6'b001000,
        PH_DATA    = 6'b010000,
        PH_DONE    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] member_number;
        logic [44:0] payload_offset;
        logic [28:0] payload_length;
        logic        archive_valid;
        logic [3:0]  error_code;
        logic [16:0] members_total;
        logic        final_result;
    } t_result;

    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_push;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic name_char_ok(input logic [7:0] b);
        logic bad;
        bad = (b == "/") || (b == "\\") || (b == ":") || (b == "*") ||
              (b == "?") || (b == "\"") || (b == "<") || (b == ">") ||
              (b == "|");
        return (b >= 8'h20) && (b <= 8'h7E) && !bad;
    endfunction

    function automatic logic [7:0] marker_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "<";
            4'd1:    c = "=";
            4'd2:    c = "=";
            4'd3:    c = "M";
            4'd4:    c = "S";
            4'd5:    c = "-";
            4'd6:    c = "T";
            4'd7:    c = "h";
            4'd8:    c = "e";
            4'd9:    c = "m";
            4'd10:   c = "e";
            4'd11:   c = "=";
            4'd12:   c = "=";
            4'd13:   c = ">";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/tasv_outq.sv
// ----------------------------------------------------------------------------
// tasv_outq
// Four-entry result queue: takes up to two results a cycle while it has room, gives one when the receiver is ready.
// ----------------------------------------------------------------------------
module tasv_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tasv_pkg::t_push   i_push,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output tasv_pkg::t_result o_result
);
    import tasv_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_head, n_head;
    logic [1:0] r_tail, n_tail;
    logic [2:0] r_count, n_count;
    logic       pop;
    logic [1:0] tail1;

    assign pop      = (r_count != 3'd0) && i_ready;
    assign o_valid  = (r_count != 3'd0);
    assign o_result = r_mem[r_head];
    assign o_room   = (r_count <= 3'd2);
    assign tail1    = r_tail + 2'd1;

    always_comb begin
        n_head  = r_head + {1'b0, pop};
        n_tail  = r_tail + {1'b0, i_push.v0} + {1'b0, i_push.v1};
        n_count = r_count - {2'b0, pop} + {2'b0, i_push.v0} + {2'b0, i_push.v1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_mem[r_tail] <= i_push.r0;
        end
        if (i_push.v1) begin
            r_mem[tail1] <= i_push.r1;
        end
    end

endmodule

>>> hdl/tasv_parser.sv
// ----------------------------------------------------------------------------
// tasv_parser
// Per-byte parser state, size table and result formation.
// ----------------------------------------------------------------------------
module tasv_parser #(
    parameter int TABLE_DEPTH        = tasv_pkg::TABLE_DEPTH_DEF,
    parameter int VERSION_MAX_LENGTH = tasv_pkg::VERSION_MAX_DEF,
    parameter int NAME_MAX_LENGTH    = tasv_pkg::NAME_MAX_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_take,
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_file,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_index,
    input  logic [28:0]     i_cfg_data,
    output tasv_pkg::t_push o_push
);
    import tasv_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [28:0] DEPTH_LIM = 29'(TABLE_DEPTH);
    localparam logic [8:0]  VER_LIM   = 9'(VERSION_MAX_LENGTH);
    localparam logic [8:0]  NAME_LIM  = 9'(NAME_MAX_LENGTH);

    logic [16:0] r_max_count;
    logic [28:0] r_max_bytes;

    t_phase      r_phase,    n_phase;
    logic [8:0]  r_len,      n_len;
    logic [28:0] r_acc,      n_acc;
    logic [5:0]  r_flags,    n_flags;
    logic [16:0] r_declared, n_declared;
    logic [16:0] r_entry,    n_entry;
    logic [3:0]  r_mpos,     n_mpos;
    logic [28:0] r_left,     n_left;
    logic [44:0] r_pos,      n_pos;
    logic [3:0]  r_err,      n_err;

    logic [28:0] r_table [TABLE_DEPTH];
    logic [28:0] r_size;

    logic        wr_en;
    logic [32:0] acc_next;
    logic [3:0]  digit;
    logic [16:0] count_cap;
    logic [28:0] bytes_cap;
    logic [17:0] entry_inc;
    logic        rec_v;
    logic [28:0] rec_len;
    logic [28:0] left_dec;
    t_result     rec;
    t_result     verdict;

    assign count_cap = (r_max_count > COUNT_CAP) ? COUNT_CAP : r_max_count;
    assign bytes_cap = (r_max_bytes > SIZE_CAP) ? SIZE_CAP : r_max_bytes;
    assign digit     = i_data_byte[3:0];
    // acc * 10 + digit
    assign acc_next  = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + {29'b0, digit};
    assign entry_inc = {1'b0, r_entry} + 18'd1;
    assign left_dec  = (r_left != '0) ? r_left - 29'd1 : r_left;

    always_comb begin
        n_phase    = r_phase;
        n_len      = r_len;
        n_acc      = r_acc;
        n_flags    = r_flags;
        n_declared = r_declared;
        n_entry    = r_entry;
        n_mpos     = r_mpos;
        n_left     = r_left;
        n_pos      = r_pos;
        n_err      = r_err;
        wr_en      = 1'b0;
        rec_v      = 1'b0;
        rec_len    = '0;

        if (i_take && r_err == ERR_NONE) begin
            case (r_phase)
                PH_VERSION: begin
                    if (i_data_byte == 8'h0A) begin
                        if (r_len == '0 || r_flags[FL_PREVDOT] || !r_flags[FL_DOT]) begin
                            n_err = ERR_VERSION;
                        end else begin
                            n_phase = PH_COUNT;
                            n_len   = '0;
                            n_flags = '0;
                            n_acc   = '0;
                        end
                    end else if (r_len >= VER_LIM) begin
                        n_err = ERR_VERSION;
                    end else if (i_data_byte == ".") begin
                        if (r_len == '0 || r_flags[FL_PREVDOT]) begin
                            n_err = ERR_VERSION;
                        end else begin
                            n_flags[FL_DOT]     = 1'b1;
                            n_flags[FL_PREVDOT] = 1'b1;
                            n_len = r_len + 9'd1;
                        end
                    end else if (is_digit(i_data_byte)) begin
                        n_flags[FL_PREVDOT] = 1'b0;
                        n_len = r_len + 9'd1;
                    end else begin
                        n_err = ERR_VERSION;
                    end
                end
                PH_COUNT: begin
                    if (i_data_byte == 8'h0A) begin
                        if (r_len == '0 || r_acc == '0) begin
                            n_err = ERR_COUNT;
                        end else if (r_acc > DEPTH_LIM) begin
                            n_err = ERR_TABLE;
                        end else begin
                            n_declared = r_acc[16:0];
                            n_entry    = '0;
                            n_phase    = PH_DIR;
                            n_len      = '0;
                            n_flags    = 6'(1 << FL_ALLDOTS);
                            n_acc      = '0;
                        end
                    end else if (!is_digit(i_data_byte) || r_len >= 9'(COUNT_DIGITS) ||
                                 (r_len == 9'd1 && r_flags[FL_FIRSTZERO])) begin
                        n_err = ERR_COUNT;
                    end else begin
                        if (r_len == '0 && i_data_byte == "0") begin
                            n_flags[FL_FIRSTZERO] = 1'b1;
                        end
                        if (acc_next > {16'b0, count_cap}) begin
                            n_err = ERR_COUNT;
                        end else begin
                            n_acc = acc_next[28:0];
                            n_len = r_len + 9'd1;
                        end
                    end
                end
                PH_DIR: begin
                    if (i_data_byte == 8'h0A) begin
                        if (!r_flags[FL_NAMEDONE]) begin
                            n_err = ERR_NAME;
                        end else if (r_flags[FL_SIZEBAD] || r_len == '0) begin
                            n_err = ERR_SIZE;
                        end else begin
                            wr_en   = 1'b1;
                            n_entry = entry_inc[16:0];
                            n_len   = '0;
                            n_flags = 6'(1 << FL_ALLDOTS);
                            n_acc   = '0;
                            if (entry_inc >= {1'b0, r_declared}) begin
                                n_entry = '0;
                                n_phase = PH_MARKER;
                                n_mpos  = '0;
                            end
                        end
                    end else if (!r_flags[FL_NAMEDONE]) begin
                        if (i_data_byte == ",") begin
                            if (r_len == '0 || (r_len <= 9'd2 && r_flags[FL_ALLDOTS])) begin
                                n_err = ERR_NAME;
                            end else begin
                                n_flags[FL_NAMEDONE] = 1'b1;
                                n_len = '0;
                                n_acc = '0;
                            end
                        end else if (!name_char_ok(i_data_byte) || r_len >= NAME_LIM) begin
                            n_err = ERR_NAME;
                        end else begin
                            if (i_data_byte != ".") begin
                                n_flags[FL_ALLDOTS] = 1'b0;
                            end
                            n_len = r_len + 9'd1;
                        end
                    end else if (i_data_byte == ",") begin
                        n_err = ERR_NAME;
                    end else if (!r_flags[FL_SIZEBAD]) begin
                        if (!is_digit(i_data_byte) || r_len >= 9'(SIZE_DIGITS) ||
                            (r_len == 9'd1 && r_flags[FL_FIRSTZERO])) begin
                            n_flags[FL_SIZEBAD] = 1'b1;
                        end else begin
                            if (r_len == '0 && i_data_byte == "0") begin
                                n_flags[FL_FIRSTZERO] = 1'b1;
                            end
                            if (acc_next > {4'b0, bytes_cap}) begin
                                n_flags[FL_SIZEBAD] = 1'b1;
                            end else begin
                                n_acc = acc_next[28:0];
                                n_len = r_len + 9'd1;
                            end
                        end
                    end
                end
                PH_MARKER: begin
                    if (r_mpos >= 4'(MARKER_LENGTH) || i_data_byte != marker_char(r_mpos)) begin
                        n_err = ERR_MARKER;
                    end else begin
                        n_mpos = r_mpos + 4'd1;
                        if (r_mpos == 4'(MARKER_LENGTH - 1)) begin
                            if (r_size == '0) begin
                                rec_v = 1'b1;
                            end else begin
                                n_left  = r_size;
                                n_phase = PH_DATA;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        rec_v   = 1'b1;
                        rec_len = r_size;
                    end
                end
                default: begin
                    n_err = ERR_TRAILING;
                end
            endcase

            if (rec_v) begin
                n_entry = entry_inc[16:0];
                if (entry_inc >= {1'b0, r_declared}) begin
                    n_phase = PH_DONE;
                end else begin
                    n_phase = PH_MARKER;
                    n_mpos  = '0;
                end
            end
        end

        rec.result_kind    = 1'b0;
        rec.member_number  = r_entry[15:0];
        rec.payload_offset = r_pos + 45'd1 - {16'b0, rec_len};
        rec.payload_length = rec_len;
        rec.archive_valid  = 1'b0;
        rec.error_code     = ERR_NONE;
        rec.members_total  = '0;
        rec.final_result   = !i_end_of_file;

        if (i_take && i_end_of_file && n_err == ERR_NONE && n_phase != PH_DONE) begin
            n_err = ERR_TRUNCATED;
        end

        verdict.result_kind    = 1'b1;
        verdict.member_number  = '0;
        verdict.payload_offset = '0;
        verdict.payload_length = '0;
        verdict.archive_valid  = (n_err == ERR_NONE);
        verdict.error_code     = n_err;
        verdict.members_total  = n_declared;
        verdict.final_result   = 1'b1;

        o_push.v0 = 1'b0;
        o_push.v1 = 1'b0;
        o_push.r0 = rec;
        o_push.r1 = verdict;
        if (i_take) begin
            if (rec_v) begin
                o_push.v0 = 1'b1;
                o_push.v1 = i_end_of_file;
            end else if (i_end_of_file) begin
                o_push.v0 = 1'b1;
                o_push.r0 = verdict;
            end
        end

        if (i_take) begin
            if (i_end_of_file) begin
                n_phase    = PH_VERSION;
                n_len      = '0;
                n_acc      = '0;
                n_flags    = '0;
                n_declared = '0;
                n_entry    = '0;
                n_mpos     = '0;
                n_left     = '0;
                n_pos      = '0;
                n_err      = ERR_NONE;
            end else begin
                n_pos = r_pos + 45'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_count <= COUNT_CAP;
            r_max_bytes <= SIZE_CAP;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAX_COUNT: r_max_count <= i_cfg_data[16:0];
                CFG_MAX_BYTES: r_max_bytes <= i_cfg_data;
                default:       r_max_count <= r_max_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_VERSION;
            r_len      <= '0;
            r_acc      <= '0;
            r_flags    <= '0;
            r_declared <= '0;
            r_entry    <= '0;
            r_mpos     <= '0;
            r_left     <= '0;
            r_pos      <= '0;
            r_err      <= ERR_NONE;
        end else begin
            r_phase    <= n_phase;
            r_len      <= n_len;
            r_acc      <= n_acc;
            r_flags    <= n_flags;
            r_declared <= n_declared;
            r_entry    <= n_entry;
            r_mpos     <= n_mpos;
            r_left     <= n_left;
            r_pos      <= n_pos;
            r_err      <= n_err;
        end
    end

    // size of the current member is prefetched; the 14-byte marker hides the latency
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[r_entry[AW-1:0]] <= r_acc;
        end
        r_size <= r_table[r_entry[AW-1:0]];
    end

endmodule

>>> hdl/theme_archive_stream_validator_top.sv
// ----------------------------------------------------------------------------
// theme_archive_stream_validator_top
// Byte-stream validator for theme archives: preamble, directory and payload.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready): one archive byte per transaction, with
// i_end_of_file on the final byte. Output channel (o_valid/i_ready): one
// result per transaction, a member record when a member's data completes
// and a verdict after the final byte; o_final_result marks the last result
// of a byte.
// One byte is taken per cycle while o_ready is high. Results are
// written into a four-entry output queue; input is held off (o_ready
// low) only while the queue has fewer than two free entries, so a
// stalled receiver stops the input once three or more results are queued.
// Configuration (i_cfg_wr_en, i_cfg_index, i_cfg_data) writes the member
// count and member size limits; write only while the block is idle.
// Synchronous active-low reset returns the parser to the version line,
// restores the default limits and empties the queue. The member size
// table needs no clearing; each entry is written before it is read.
// ----------------------------------------------------------------------------
module theme_archive_stream_validator_top #(
    parameter int TABLE_DEPTH        = tasv_pkg::TABLE_DEPTH_DEF,
    parameter int VERSION_MAX_LENGTH = tasv_pkg::VERSION_MAX_DEF,
    parameter int NAME_MAX_LENGTH    = tasv_pkg::NAME_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_file,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [28:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_result_kind,
    output logic [15:0] o_member_number,
    output logic [44:0] o_payload_offset,
    output logic [28:0] o_payload_length,
    output logic        o_archive_valid,
    output logic [3:0]  o_error_code,
    output logic [16:0] o_members_total,
    output logic        o_final_result
);
    import tasv_pkg::*;

    t_push   push;
    t_result res;
    logic    room;

    assign o_ready = room;

    tasv_parser #(
        .TABLE_DEPTH       (TABLE_DEPTH),
        .VERSION_MAX_LENGTH(VERSION_MAX_LENGTH),
        .NAME_MAX_LENGTH   (NAME_MAX_LENGTH)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (i_valid && room),
        .i_data_byte  (i_data_byte),
        .i_end_of_file(i_end_of_file),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_push       (push)
    );

    tasv_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_result(res)
    );

    assign o_result_kind    = res.result_kind;
    assign o_member_number  = res.member_number;
    assign o_payload_offset = res.payload_offset;
    assign o_payload_length = res.payload_length;
    assign o_archive_valid  = res.archive_valid;
    assign o_error_code     = res.error_code;
    assign o_members_total  = res.members_total;
    assign o_final_result   = res.final_result;

endmodule

>>> test/tb_theme_archive_stream_validator_top.sv
// ----------------------------------------------------------------------------
// tb_theme_archive_stream_validator_top
// Self-checking bench for the theme archive validator: a table of directed
// archives, then random archives (mostly well formed, some corrupted, some
// noise) under several limit settings and idle/stall mixes. Each accepted byte
// runs through a behavioral parser and the member records and verdicts it
// predicts are compared in order with what the block returns.
// ----------------------------------------------------------------------------
module tb_theme_archive_stream_validator_top;
    import tasv_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    // directed table carries close to a thousand bytes; this tops it up
    localparam int RANDOM_BYTES = 260;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = 8'd0;
    logic        i_end_of_file = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_index = CFG_MAX_COUNT;
    logic [28:0] i_cfg_data = 29'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_result_kind;
    logic [15:0] o_member_number;
    logic [44:0] o_payload_offset;
    logic [28:0] o_payload_length;
    logic        o_archive_valid;
    logic [3:0]  o_error_code;
    logic [16:0] o_members_total;
    logic        o_final_result;

    theme_archive_stream_validator_top u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------- parser state mirror ----------------
    logic [16:0] lim_count = COUNT_CAP;
    logic [28:0] lim_bytes = SIZE_CAP;
    t_phase      ph = PH_VERSION;
    int unsigned line_len, acc, entry, decl_count, mpos, left;
    logic [6:0]  flags;
    logic [28:0] sizes [1024];
    logic [44:0] pos;
    logic [3:0]  err;
    int          last_verdict_err;
    string       marker_text = "<==MS-Theme==>";

    t_result expected_results[$];
    t_result step_results[$];

    int unsigned cycle_count = 0;
    int          fail_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;

    function automatic void clear_parse();
        ph = PH_VERSION;
        line_len = 0; acc = 0; entry = 0; decl_count = 0;
        mpos = 0; left = 0; flags = '0; pos = '0; err = ERR_NONE;
        foreach (sizes[k]) sizes[k] = '0;
    endfunction

    function automatic bit digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit name_ok(input logic [7:0] b);
        if (b < 8'h20 || b > 8'h7E) return 0;
        return !(b == "/" || b == "\\" || b == ":" || b == "*" || b == "?" ||
                 b == "\"" || b == "<" || b == ">" || b == "|");
    endfunction

    function automatic void member_done(input logic [28:0] len);
        t_result r;
        r = '0;
        r.member_number  = entry[15:0];
        r.payload_offset = pos + 45'd1 - 45'(len);
        r.payload_length = len;
        step_results.push_back(r);
        entry++;
        if (entry >= decl_count) ph = PH_DONE;
        else begin
            ph = PH_MARKER;
            mpos = 0;
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        int unsigned cap;
        logic [28:0] sz;
        case (ph)
            PH_VERSION: begin
                if (b == 8'h0A) begin
                    if (line_len == 0 || flags[FL_PREVDOT] || !flags[FL_DOT]) err = ERR_VERSION;
                    else begin
                        ph = PH_COUNT; line_len = 0; flags = '0; acc = 0;
                    end
                end else if (line_len >= 32) begin
                    err = ERR_VERSION;
                end else if (b == ".") begin
                    if (line_len == 0 || flags[FL_PREVDOT]) err = ERR_VERSION;
                    else begin
                        flags[FL_DOT] = 1'b1; flags[FL_PREVDOT] = 1'b1; line_len++;
                    end
                end else if (digit(b)) begin
                    flags[FL_PREVDOT] = 1'b0; line_len++;
                end else begin
                    err = ERR_VERSION;
                end
            end
            PH_COUNT: begin
                if (b == 8'h0A) begin
                    if (line_len == 0 || acc == 0) err = ERR_COUNT;
                    else if (acc > 1024) err = ERR_TABLE;
                    else begin
                        decl_count = acc; entry = 0; ph = PH_DIR; line_len = 0;
                        flags = '0; flags[FL_ALLDOTS] = 1'b1; acc = 0;
                    end
                end else begin
                    cap = (lim_count > COUNT_CAP) ? COUNT_CAP : lim_count;
                    if (!digit(b) || line_len >= 7 || (line_len == 1 && flags[FL_FIRSTZERO])) begin
                        err = ERR_COUNT;
                    end else begin
                        if (line_len == 0 && b == "0") flags[FL_FIRSTZERO] = 1'b1;
                        acc = acc * 10 + (32'(b) - 32'd48);
                        if (acc > cap) err = ERR_COUNT;
                        else line_len++;
                    end
                end
            end
            PH_DIR: begin
                if (b == 8'h0A) begin
                    if (!flags[FL_NAMEDONE]) err = ERR_NAME;
                    else if (flags[FL_SIZEBAD] || line_len == 0) err = ERR_SIZE;
                    else begin
                        if (entry < 1024) sizes[entry] = acc[28:0];
                        entry++;
                        line_len = 0; flags = '0; flags[FL_ALLDOTS] = 1'b1; acc = 0;
                        if (entry >= decl_count) begin
                            entry = 0; ph = PH_MARKER; mpos = 0;
                        end
                    end
                end else if (!flags[FL_NAMEDONE]) begin
                    if (b == ",") begin
                        if (line_len == 0 || (line_len <= 2 && flags[FL_ALLDOTS])) err = ERR_NAME;
                        else begin
                            flags[FL_NAMEDONE] = 1'b1; line_len = 0; acc = 0;
                        end
                    end else if (!name_ok(b) || line_len >= 255) begin
                        err = ERR_NAME;
                    end else begin
                        if (b != ".") flags[FL_ALLDOTS] = 1'b0;
                        line_len++;
                    end
                end else if (b == ",") begin
                    err = ERR_NAME;
                end else if (!flags[FL_SIZEBAD]) begin
                    cap = (lim_bytes > SIZE_CAP) ? SIZE_CAP : lim_bytes;
                    if (!digit(b) || line_len >= 10 || (line_len == 1 && flags[FL_FIRSTZERO])) begin
                        flags[FL_SIZEBAD] = 1'b1;
                    end else begin
                        if (line_len == 0 && b == "0") flags[FL_FIRSTZERO] = 1'b1;
                        acc = acc * 10 + (32'(b) - 32'd48);
                        if (acc > cap) flags[FL_SIZEBAD] = 1'b1;
                        else line_len++;
                    end
                end
            end
            PH_MARKER: begin
                if (mpos >= 14 || b != marker_text[mpos]) err = ERR_MARKER;
                else begin
                    mpos++;
                    if (mpos == 14) begin
                        sz = (entry < 1024) ? sizes[entry] : '0;
                        if (sz == 0) member_done('0);
                        else begin
                            left = sz; ph = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA: begin
                if (left > 0) left--;
                if (left == 0) member_done((entry < 1024) ? sizes[entry] : '0);
            end
            default: err = ERR_TRAILING;
        endcase
    endfunction

    function automatic void archive_predict(input logic [7:0] b, input logic eof);
        t_result r;
        step_results.delete();
        if (err == ERR_NONE) parse_byte(b);
        if (eof) begin
            if (err == ERR_NONE && ph != PH_DONE) err = ERR_TRUNCATED;
            r = '0;
            r.result_kind   = 1'b1;
            r.archive_valid = (err == ERR_NONE);
            r.error_code    = err;
            r.members_total = decl_count[16:0];
            step_results.push_back(r);
            last_verdict_err = err;
            clear_parse();
        end else begin
            pos = pos + 45'd1;
        end
        if (step_results.size() > 0) step_results[step_results.size()-1].final_result = 1'b1;
        foreach (step_results[k]) expected_results.push_back(step_results[k]);
    endfunction

    // ---------------- monitor and scoreboard ----------------
    always @(posedge i_clk) begin
        t_result got, want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        if (i_rst_n) begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_MAX_COUNT) lim_count = i_cfg_data[16:0];
                else lim_bytes = i_cfg_data;
            end
            if (i_valid && o_ready) archive_predict(i_data_byte, i_end_of_file);
            if (o_valid && i_ready) begin
                got = {o_result_kind, o_member_number, o_payload_offset, o_payload_length,
                       o_archive_valid, o_error_code, o_members_total, o_final_result};
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: kind %0d/%0d num %0d/%0d off %0d/%0d len %0d/%0d ok %0d/%0d err %0d/%0d tot %0d/%0d fin %0d/%0d",
                                     want.result_kind, got.result_kind,
                                     want.member_number, got.member_number,
                                     want.payload_offset, got.payload_offset,
                                     want.payload_length, got.payload_length,
                                     want.archive_valid, got.archive_valid,
                                     want.error_code, got.error_code,
                                     want.members_total, got.members_total,
                                     want.final_result, got.final_result);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) i_ready <= ($urandom_range(99) >= stall_pct);

    // ---------------- drivers (entered and left at a falling edge) ----------------
    task automatic send_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_end_of_file <= eof;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_limits(input logic [28:0] count_lim, input logic [28:0] bytes_lim);
        drain();
        repeat (10) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1; i_cfg_index <= CFG_MAX_COUNT; i_cfg_data <= count_lim;
        @(negedge i_clk);
        i_cfg_index <= CFG_MAX_BYTES; i_cfg_data <= bytes_lim;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_archive(ref logic [7:0] q[$]);
        foreach (q[k]) send_byte(q[k], k == q.size() - 1);
    endtask

    // ---------------- archive builders ----------------
    function automatic void add_text(ref logic [7:0] q[$], input string s);
        for (int k = 0; k < s.len(); k++) q.push_back(s[k]);
    endfunction

    function automatic string repeat_char(input byte c, input int n);
        string s;
        s = "";
        for (int k = 0; k < n; k++) s = {s, string'(c)};
        return s;
    endfunction

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h20, 8'h7E)); while (!name_ok(c) || c == ",");
        return c;
    endfunction

    function automatic void build_archive(ref logic [7:0] q[$]);
        int unsigned cnt_cap, size_cap, n, groups, mode, cut;
        int unsigned sz[$];
        q.delete();
        mode = $urandom_range(99);
        if (mode < 12) begin
            // pure noise
            repeat ($urandom_range(1, 30)) q.push_back(8'($urandom));
            return;
        end
        groups = $urandom_range(2, 4);
        for (int g = 0; g < groups; g++) begin
            if (g > 0) q.push_back(".");
            repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range("0", "9")));
        end
        q.push_back(8'h0A);
        cnt_cap = (lim_count > COUNT_CAP) ? COUNT_CAP : lim_count;
        size_cap = (lim_bytes > SIZE_CAP) ? SIZE_CAP : lim_bytes;
        n = $urandom_range(1, (cnt_cap < 4) ? cnt_cap : 4);
        add_text(q, $sformatf("%0d\n", n));
        for (int m = 0; m < n; m++) begin
            repeat ($urandom_range(1, 8)) q.push_back(name_char());
            sz.push_back($urandom_range(0, (size_cap < 20) ? size_cap : 20));
            add_text(q, $sformatf(",%0d\n", sz[m]));
        end
        for (int m = 0; m < n; m++) begin
            add_text(q, marker_text);
            repeat (sz[m]) q.push_back(8'($urandom));
        end
        if (mode < 22) begin
            q[$urandom_range(0, q.size() - 1)] = 8'($urandom);
        end else if (mode < 30) begin
            cut = $urandom_range(1, q.size() - 1);
            while (q.size() > cut) void'(q.pop_back());
        end else if (mode < 36) begin
            repeat ($urandom_range(1, 3)) q.push_back(8'($urandom));
        end
    endfunction

    // ---------------- directed cases ----------------
    typedef struct {
        string text;
        int    want_err;   // -1: predictor only
    } t_case;

    t_case directed_cases[$];

    function automatic void add_case(input string s, input int e);
        t_case c;
        c.text = s; c.want_err = e;
        directed_cases.push_back(c);
    endfunction

    initial begin
        logic [7:0] q[$];
        string mk;
        int random_sent;
        int phase_target;
        int idle_set [5] = '{0, 64, 0, 36, 0};
        int stall_set[5] = '{0, 0, 64, 36, 0};
        logic [28:0] cnt_set [5] = '{29'd65536, 29'd1, 29'h1FFFF, 29'd3, 29'd5};
        logic [28:0] byte_set[5] = '{29'h1000_0000, 29'd0, 29'h1FFF_FFFF, 29'd40, 29'd12};

        mk = marker_text;
        clear_parse();
        add_case({"1.0\n1\na,3\n", mk, "xyz"}, ERR_NONE);
        add_case({"1.0\n1\na,0\n", mk}, ERR_NONE);
        add_case({"1.", repeat_char("7", 30), "\n2\n...,1\nb,0\n", mk, "Q", mk}, ERR_NONE);
        add_case({"1.", repeat_char("7", 31), "\n"}, ERR_VERSION);
        add_case("10\n1", ERR_VERSION);
        add_case(".1\n", ERR_VERSION);
        add_case("1..2\n", ERR_VERSION);
        add_case("1.\n", ERR_VERSION);
        add_case("\n", ERR_VERSION);
        add_case("x", ERR_VERSION);
        add_case("1.0\n0\n", ERR_COUNT);
        add_case("1.0\n01\n", ERR_COUNT);
        add_case("1.0\n65537\n", ERR_COUNT);
        add_case("1.0\n1025\n", ERR_TABLE);
        add_case("1.0\n1024\n", ERR_TRUNCATED);
        add_case("1.0\n1\n,5\n", ERR_NAME);
        add_case("1.0\n1\n.,1\n", ERR_NAME);
        add_case("1.0\n1\n..,1\n", ERR_NAME);
        add_case("1.0\n1\na,1,2\n", ERR_NAME);
        add_case("1.0\n1\nab\n", ERR_NAME);
        add_case("1.0\n1\na/b,1\n", ERR_NAME);
        add_case({"1.0\n1\n", repeat_char("n", 255), ",0\n", mk}, ERR_NONE);
        add_case({"1.0\n1\n", repeat_char("n", 256), ",0\n"}, ERR_NAME);
        add_case("1.0\n1\na,\n", ERR_SIZE);
        add_case("1.0\n1\na,01\n", ERR_SIZE);
        add_case("1.0\n1\na,268435457\n", ERR_SIZE);
        add_case("1.0\n1\na,268435456\n<==", ERR_TRUNCATED);
        add_case("1.0\n1\na,0\n<==MS-Theme=X>", ERR_MARKER);
        add_case({"1.0\n1\na,2\n", mk, "ab!"}, ERR_TRAILING);
        add_case({"1.0\n2\na,1\nb,1\n", mk, "z"}, ERR_TRUNCATED);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_cases[c]) begin
            q.delete();
            add_text(q, directed_cases[c].text);
            send_archive(q);
            if (directed_cases[c].want_err >= 0 && last_verdict_err != directed_cases[c].want_err) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("case %0d: verdict %0d, table says %0d",
                             c, last_verdict_err, directed_cases[c].want_err);
            end
        end

        random_sent = 0;
        for (int p = 0; p < 5; p++) begin
            write_limits(cnt_set[p], byte_set[p]);
            send_idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            phase_target = RANDOM_BYTES * (p + 1) / 5;
            while (random_sent < phase_target) begin
                build_archive(q);
                send_archive(q);
                random_sent += q.size();
                // occasional hold-off until the output side has caught up
                if ($urandom_range(9) == 0) drain();
            end
        end

        drain();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

>>> theme_archive_stream_validator_top.f
hdl/tasv_pkg.sv
hdl/tasv_outq.sv
hdl/tasv_parser.sv
hdl/theme_archive_stream_validator_top.sv
test/tb_theme_archive_stream_validator_top.sv
